/* src/ubxfr_pkg.sv */
package ubxfr_pkg;

	// configuration port
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECT_CLASS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECT_ID     = 2'd2;

	localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;
	localparam logic [7:0]  RST_EXPECT_CLASS  = 8'd1;
	localparam logic [7:0]  RST_EXPECT_ID     = 8'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_CKSUM = 2'd1;
	localparam logic [1:0] ST_OTHER_MSG = 2'd2;
	localparam logic [1:0] ST_TIMEOUT   = 2'd3;

	// frame constants
	localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
	localparam logic [7:0]  SYNC_SECOND = 8'h62;
	localparam logic [15:0] POS_FIRST   = 16'd4;
	localparam logic [15:0] POS_LAST    = 16'd11;
	localparam logic [15:0] TICKS_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  expect_class;
		logic [7:0]  expect_id;
	} cfg_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         msg_class;
		logic [7:0]         msg_id;
		logic [15:0]        payload_length;
		logic signed [31:0] longitude;
		logic signed [31:0] latitude;
	} result_t;

endpackage

/* src/ubxfr_if.sv */
interface ubxfr_item_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, cmd, rx_byte, input ready);
	modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface ubxfr_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [7:0]         msg_class;
	logic [7:0]         msg_id;
	logic [15:0]        payload_length;
	logic signed [31:0] longitude;
	logic signed [31:0] latitude;

	modport source (output valid, status, msg_class, msg_id, payload_length, longitude,
		latitude, input ready);
	modport sink (input valid, status, msg_class, msg_id, payload_length, longitude,
		latitude, output ready);
endinterface

/* src/ubxfr_cfg_regs.sv */
module ubxfr_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ubxfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ubxfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ubxfr_pkg::cfg_t                      cfg
);

	ubxfr_pkg::cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= ubxfr_pkg::RST_TIMEOUT_TICKS;
			cfg_q.expect_class  <= ubxfr_pkg::RST_EXPECT_CLASS;
			cfg_q.expect_id     <= ubxfr_pkg::RST_EXPECT_ID;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ubxfr_pkg::CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				ubxfr_pkg::CFG_EXPECT_CLASS:  cfg_q.expect_class  <= cfg_data[7:0];
				ubxfr_pkg::CFG_EXPECT_ID:     cfg_q.expect_id     <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/ubxfr_in_reg.sv */
module ubxfr_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	ubxfr_item_if.sink        items,
	input  logic              take,
	output logic              item_v_s1,
	output ubxfr_pkg::item_t  item_s1
);

	logic advance;

	// stage empties whenever the result side can take its outcome
	assign advance     = item_v_s1 && take;
	assign items.ready = !item_v_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (items.ready) begin
			item_v_s1 <= items.valid;
		end else if (advance) begin
			item_v_s1 <= 1'b0;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.cmd     <= items.cmd;
			item_s1.rx_byte <= items.rx_byte;
		end
	end

endmodule

/* src/ubxfr_parser.sv */
module ubxfr_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  ubxfr_pkg::cfg_t     cfg,
	input  logic                fire,
	input  ubxfr_pkg::item_t    item,
	output logic                res_v,
	output ubxfr_pkg::result_t  res
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_CLASS,
		PH_ID,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_CK_A,
		PH_CK_B
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] idx_q, idx_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [7:0]  rx_sum_a_q, rx_sum_a_d;
	logic [63:0] cap_q, cap_d;
	logic [63:0] coord_q, coord_d;
	logic [15:0] ticks_q, ticks_d;

	logic [7:0]  b;
	logic [7:0]  sum_a_add;
	logic [7:0]  sum_b_add;
	logic [15:0] ticks_inc;
	logic [15:0] idx_inc;
	logic [15:0] len_full;
	logic [2:0]  lane;

	assign b         = item.rx_byte;
	assign sum_a_add = sum_a_q + b;
	assign sum_b_add = sum_b_q + sum_a_add;
	assign ticks_inc = (ticks_q != ubxfr_pkg::TICKS_MAX) ? ticks_q + 16'd1 : ticks_q;
	assign idx_inc   = idx_q + 16'd1;
	assign len_full  = {b, len_q[7:0]};
	assign lane      = idx_q[2:0] - 3'd4;

	// next state and result for the item in the input stage
	always_comb begin
		phase_d    = phase_q;
		prev_d     = prev_q;
		class_d    = class_q;
		id_d       = id_q;
		len_d      = len_q;
		idx_d      = idx_q;
		sum_a_d    = sum_a_q;
		sum_b_d    = sum_b_q;
		rx_sum_a_d = rx_sum_a_q;
		cap_d      = cap_q;
		coord_d    = coord_q;
		ticks_d    = ticks_q;
		res_v      = 1'b0;
		res.status         = ubxfr_pkg::ST_OK;
		res.msg_class      = class_q;
		res.msg_id         = id_q;
		res.payload_length = len_q;

		if (item.cmd) begin
			// time tick, counted only while hunting
			if (phase_q == PH_HUNT) begin
				ticks_d = ticks_inc;
				if (ticks_inc >= cfg.timeout_ticks) begin
					ticks_d            = '0;
					res_v              = 1'b1;
					res.status         = ubxfr_pkg::ST_TIMEOUT;
					res.msg_class      = '0;
					res.msg_id         = '0;
					res.payload_length = '0;
				end
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (prev_q == ubxfr_pkg::SYNC_FIRST && b == ubxfr_pkg::SYNC_SECOND) begin
						phase_d = PH_CLASS;
						ticks_d = '0;
						sum_a_d = '0;
						sum_b_d = '0;
						cap_d   = '0;
						idx_d   = '0;
					end
					prev_d = b;
				end
				PH_CLASS: begin
					class_d = b;
					sum_a_d = sum_a_add;
					sum_b_d = sum_b_add;
					phase_d = PH_ID;
				end
				PH_ID: begin
					id_d    = b;
					sum_a_d = sum_a_add;
					sum_b_d = sum_b_add;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = {8'd0, b};
					sum_a_d = sum_a_add;
					sum_b_d = sum_b_add;
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d   = len_full;
					sum_a_d = sum_a_add;
					sum_b_d = sum_b_add;
					idx_d   = '0;
					phase_d = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					sum_a_d = sum_a_add;
					sum_b_d = sum_b_add;
					// position bytes land in their lane of the capture word
					if (idx_q >= ubxfr_pkg::POS_FIRST && idx_q <= ubxfr_pkg::POS_LAST) begin
						cap_d[{lane, 3'b000} +: 8] = b;
					end
					idx_d = idx_inc;
					if (idx_inc >= len_q) begin
						phase_d = PH_CK_A;
					end
				end
				PH_CK_A: begin
					rx_sum_a_d = b;
					phase_d    = PH_CK_B;
				end
				PH_CK_B: begin
					// checksum first, then class and id
					if (rx_sum_a_q != sum_a_q || b != sum_b_q) begin
						res.status = ubxfr_pkg::ST_BAD_CKSUM;
					end else if (class_q == cfg.expect_class && id_q == cfg.expect_id) begin
						res.status = ubxfr_pkg::ST_OK;
						coord_d    = cap_q;
					end else begin
						res.status = ubxfr_pkg::ST_OTHER_MSG;
					end
					res_v   = 1'b1;
					phase_d = PH_HUNT;
					prev_d  = '0;
					ticks_d = '0;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end

		res.longitude = $signed(coord_d[31:0]);
		res.latitude  = $signed(coord_d[63:32]);
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			prev_q     <= '0;
			class_q    <= '0;
			id_q       <= '0;
			len_q      <= '0;
			idx_q      <= '0;
			sum_a_q    <= '0;
			sum_b_q    <= '0;
			rx_sum_a_q <= '0;
			cap_q      <= '0;
			coord_q    <= '0;
			ticks_q    <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			prev_q     <= prev_d;
			class_q    <= class_d;
			id_q       <= id_d;
			len_q      <= len_d;
			idx_q      <= idx_d;
			sum_a_q    <= sum_a_d;
			sum_b_q    <= sum_b_d;
			rx_sum_a_q <= rx_sum_a_d;
			cap_q      <= cap_d;
			coord_q    <= coord_d;
			ticks_q    <= ticks_d;
		end
	end

endmodule

/* src/ubxfr_out_reg.sv */
module ubxfr_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ubxfr_pkg::result_t  res,
	output logic                take,
	ubxfr_result_if.source      results
);

	logic               res_v_q;
	ubxfr_pkg::result_t res_q;

	// free when empty or being drained this cycle
	assign take = !res_v_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (load) begin
			res_v_q <= 1'b1;
		end else if (results.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign results.valid          = res_v_q;
	assign results.status         = res_q.status;
	assign results.msg_class      = res_q.msg_class;
	assign results.msg_id         = res_q.msg_id;
	assign results.payload_length = res_q.payload_length;
	assign results.longitude      = res_q.longitude;
	assign results.latitude       = res_q.latitude;

endmodule

/* src/ubx_frame_receiver_position.sv */
// channel   | dir | request carries
// ----------+-----+-------------------------------------------------------------
// items     | in  | cmd (byte or tick), rx_byte
// results   | out | status, msg_class, msg_id, payload_length, longitude, latitude
// cfg port  | in  | cfg_we, cfg_index, cfg_data (no read-back)
//
// One request per cycle sustained while results are taken; results.valid
// comes from the output register, loaded as the request leaves the input register.
// Each request goes through an input register and one step of the frame state
// machine; a request that yields a result then loads the output register.
// arst_n clears all frame state; registers return to 1000 / class 1 / id 2.
// A stalled result holds the output register and freezes the state machine;
// an empty input register still takes one request, then ready stays low until
// the result is taken.
module ubx_frame_receiver_position (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ubxfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ubxfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	ubxfr_item_if.sink                         items,
	ubxfr_result_if.source                     results
);

	ubxfr_pkg::cfg_t    cfg;
	ubxfr_pkg::item_t   item_s1;
	ubxfr_pkg::result_t res;
	logic               item_v_s1;
	logic               take;
	logic               fire;
	logic               res_v;

	assign fire = item_v_s1 && take;

	ubxfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ubxfr_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.take      (take),
		.item_v_s1 (item_v_s1),
		.item_s1   (item_s1)
	);

	ubxfr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.res_v  (res_v),
		.res    (res)
	);

	ubxfr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && res_v),
		.res     (res),
		.take    (take),
		.results (results)
	);

endmodule

/* src/ubxfr_checker.sv */
module ubxfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_status,
	input logic [7:0]  res_class,
	input logic [7:0]  res_id,
	input logic [15:0] res_length
);

	// a timeout result carries no frame header
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ubxfr_pkg::ST_TIMEOUT |->
		res_class == 8'd0 && res_id == 8'd0 && res_length == 16'd0)
		else $error("timeout result with frame header fields set");

	// a stalled result is not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status))
		else $error("stalled result lost or changed");

	// a fresh result needs a prior accepted request
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a prior request");

	// no result appears from an empty pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !$past(in_valid && in_ready) |=> !res_valid)
		else $error("result from an empty pipeline");

endmodule

bind ubx_frame_receiver_position ubxfr_checker u_ubxfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_status (results.status),
	.res_class  (results.msg_class),
	.res_id     (results.msg_id),
	.res_length (results.payload_length)
);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	localparam logic [ubxfr_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int PHASE_ITEMS = 220;

	typedef enum logic [2:0] {
		PH_HUNT, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CK_A, PH_CK_B
	} parse_phase_t;

	// frame parser predictor and store of expected results
	class frame_scoreboard;
		logic [15:0]        tick_limit;
		logic [7:0]         want_class;
		logic [7:0]         want_id;
		parse_phase_t       phase;
		logic [7:0]         prev_byte;
		logic [7:0]         frame_class;
		logic [7:0]         frame_id;
		logic [15:0]        frame_length;
		logic [15:0]        byte_index;
		logic [7:0]         sum_a;
		logic [7:0]         sum_b;
		logic [7:0]         rx_sum_a;
		logic [63:0]        coord_capture;
		logic [63:0]        coord_out;
		logic [15:0]        hunt_ticks;
		ubxfr_pkg::result_t expected_q[$];
		int                 errors;

		function new();
			tick_limit    = ubxfr_pkg::RST_TIMEOUT_TICKS;
			want_class    = ubxfr_pkg::RST_EXPECT_CLASS;
			want_id       = ubxfr_pkg::RST_EXPECT_ID;
			phase         = PH_HUNT;
			prev_byte     = '0;
			frame_class   = '0;
			frame_id      = '0;
			frame_length  = '0;
			byte_index    = '0;
			sum_a         = '0;
			sum_b         = '0;
			rx_sum_a      = '0;
			coord_capture = '0;
			coord_out     = '0;
			hunt_ticks    = '0;
			errors        = 0;
		endfunction

		function void set_reg(logic [ubxfr_pkg::CFG_INDEX_W-1:0] idx,
			logic [ubxfr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ubxfr_pkg::CFG_TIMEOUT_TICKS: tick_limit = data;
				ubxfr_pkg::CFG_EXPECT_CLASS:  want_class = data[7:0];
				ubxfr_pkg::CFG_EXPECT_ID:     want_id = data[7:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void add_sum(logic [7:0] b);
			sum_a = sum_a + b;
			sum_b = sum_b + sum_a;
		endfunction

		function void push_result(logic [1:0] st, logic [7:0] cls, logic [7:0] id,
			logic [15:0] len);
			ubxfr_pkg::result_t r;
			r.status         = st;
			r.msg_class      = cls;
			r.msg_id         = id;
			r.payload_length = len;
			r.longitude      = coord_out[31:0];
			r.latitude       = coord_out[63:32];
			expected_q.push_back(r);
		endfunction

		// one accepted request: advance the parser and queue any result
		function void note_request(logic cmd, logic [7:0] b);
			logic [1:0] st;
			int         sh;
			if (cmd) begin
				// ticks only count while hunting
				if (phase != PH_HUNT)
					return;
				if (hunt_ticks != ubxfr_pkg::TICKS_MAX)
					hunt_ticks++;
				if (hunt_ticks >= tick_limit) begin
					hunt_ticks = '0;
					push_result(ubxfr_pkg::ST_TIMEOUT, 8'h00, 8'h00, 16'h0000);
				end
				return;
			end
			case (phase)
				PH_HUNT: begin
					if (prev_byte == ubxfr_pkg::SYNC_FIRST && b == ubxfr_pkg::SYNC_SECOND) begin
						phase         = PH_CLASS;
						hunt_ticks    = '0;
						sum_a         = '0;
						sum_b         = '0;
						coord_capture = '0;
						byte_index    = '0;
					end
					prev_byte = b;
				end
				PH_CLASS: begin
					frame_class = b;
					add_sum(b);
					phase = PH_ID;
				end
				PH_ID: begin
					frame_id = b;
					add_sum(b);
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					frame_length = {8'h00, b};
					add_sum(b);
					phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					frame_length[15:8] = b;
					add_sum(b);
					byte_index = '0;
					phase = (frame_length == 16'd0) ? PH_CK_A : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					add_sum(b);
					// position words sit at payload offsets 4..11
					if (byte_index >= ubxfr_pkg::POS_FIRST &&
						byte_index <= ubxfr_pkg::POS_LAST) begin
						sh = (int'(byte_index) - 4) * 8;
						coord_capture[sh +: 8] = b;
					end
					byte_index++;
					if (byte_index >= frame_length)
						phase = PH_CK_A;
				end
				PH_CK_A: begin
					rx_sum_a = b;
					phase = PH_CK_B;
				end
				default: begin
					// checksum is judged before class and id
					if (rx_sum_a != sum_a || b != sum_b) begin
						st = ubxfr_pkg::ST_BAD_CKSUM;
					end else if (frame_class == want_class && frame_id == want_id) begin
						st = ubxfr_pkg::ST_OK;
						coord_out = coord_capture;
					end else begin
						st = ubxfr_pkg::ST_OTHER_MSG;
					end
					phase      = PH_HUNT;
					prev_byte  = '0;
					hunt_ticks = '0;
					push_result(st, frame_class, frame_id, frame_length);
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
					want, got);
			end
		endfunction

		// one accepted result against the oldest expectation
		function void check_result(ubxfr_pkg::result_t got);
			ubxfr_pkg::result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d",
					$time, got.status);
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("msg_class", want.msg_class, got.msg_class);
			compare_field("msg_id", want.msg_id, got.msg_id);
			compare_field("payload_length", want.payload_length, got.payload_length);
			compare_field("longitude", want.longitude, got.longitude);
			compare_field("latitude", want.latitude, got.latitude);
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_we;
	logic [ubxfr_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [ubxfr_pkg::CFG_DATA_W-1:0]  cfg_data;

	ubxfr_item_if   item_ch ();
	ubxfr_result_if result_ch ();

	frame_scoreboard sb = new();

	bit     send_idle = 1'b1;
	bit     recv_idle = 1'b1;
	int     hold_request = 0;
	int     stim_items = 0;
	longint cycle_count = 0;

	ubx_frame_receiver_position dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (item_ch),
		.results   (result_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		while (cycle_count < LIMIT_CYCLES)
			@(posedge clk) cycle_count++;
		$display("Simulation FAILED");
		$finish;
	end

	// result ready: random stalls plus requested hold-off
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				result_ch.ready <= 1'b0;
				hold_request--;
			end else if (recv_idle && $urandom_range(99) < 16) begin
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result('{result_ch.status, result_ch.msg_class, result_ch.msg_id,
				result_ch.payload_length, result_ch.longitude, result_ch.latitude});
	end

	// one request, with random idle cycles in front
	task automatic send_item(input logic c, input logic [7:0] b, input bit counted = 1'b1);
		@(negedge clk);
		while (send_idle && $urandom_range(99) < 16) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.cmd     <= c;
		item_ch.rx_byte <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sb.note_request(c, b);
		if (counted)
			stim_items++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		item_ch.valid <= 1'b0;
	endtask

	// wait until every expected result is in, then let the pipeline settle
	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ubxfr_pkg::CFG_INDEX_W-1:0] idx,
		input logic [ubxfr_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic idle_and_config(input logic [15:0] ticks, input logic [15:0] cls,
		input logic [15:0] id);
		stop_sending();
		wait_drained();
		write_reg(ubxfr_pkg::CFG_TIMEOUT_TICKS, ticks);
		write_reg(ubxfr_pkg::CFG_EXPECT_CLASS, cls);
		write_reg(ubxfr_pkg::CFG_EXPECT_ID, id);
	endtask

	// full frame; damage 1 or 2 spoils the first or second checksum byte
	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
		input logic [15:0] len, input int damage, input int tick_pct);
		logic [7:0] body[$];
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		int         i;
		body.push_back(cls);
		body.push_back(id);
		body.push_back(len[7:0]);
		body.push_back(len[15:8]);
		for (i = 0; i < int'(len); i++)
			body.push_back(8'($urandom));
		ck_a = '0;
		ck_b = '0;
		foreach (body[k]) begin
			ck_a = ck_a + body[k];
			ck_b = ck_b + ck_a;
		end
		if (damage == 1)
			ck_a = ck_a ^ 8'($urandom_range(1, 255));
		if (damage == 2)
			ck_b = ck_b ^ 8'($urandom_range(1, 255));
		send_item(1'b0, ubxfr_pkg::SYNC_FIRST);
		send_item(1'b0, ubxfr_pkg::SYNC_SECOND);
		foreach (body[k]) begin
			if ($urandom_range(99) < tick_pct)
				send_item(1'b1, 8'($urandom), 1'b0);
			send_item(1'b0, body[k]);
		end
		send_item(1'b0, ck_a);
		send_item(1'b0, ck_b);
	endtask

	// mostly good frames, some noise, hunting ticks and cut-off frames
	task automatic random_traffic(input int count);
		int          start;
		int          r;
		int          n;
		int          i;
		logic [7:0]  cls;
		logic [7:0]  id;
		logic [15:0] len;
		start = stim_items;
		while (stim_items - start < count) begin
			r = $urandom_range(99);
			if (r < 68) begin
				cls = ($urandom_range(3) != 0) ? sb.want_class : 8'($urandom);
				id  = ($urandom_range(3) != 0) ? sb.want_id : 8'($urandom);
				len = ($urandom_range(9) != 0) ? 16'($urandom_range(16))
					: 16'($urandom_range(17, 80));
				send_frame(cls, id, len, ($urandom_range(4) == 0) ?
					$urandom_range(1, 2) : 0, 5);
			end else if (r < 78) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					send_item(1'b0, ($urandom_range(9) == 0) ?
						ubxfr_pkg::SYNC_FIRST : 8'($urandom));
			end else if (r < 92) begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++)
					send_item(1'b1, 8'($urandom));
			end else begin
				// header with a short length, payload cut off part way
				len = 16'($urandom_range(1, 20));
				send_item(1'b0, ubxfr_pkg::SYNC_FIRST);
				send_item(1'b0, ubxfr_pkg::SYNC_SECOND);
				send_item(1'b0, sb.want_class);
				send_item(1'b0, ($urandom_range(1) != 0) ? sb.want_id : 8'($urandom));
				send_item(1'b0, len[7:0]);
				send_item(1'b0, 8'h00);
				n = $urandom_range(0, int'(len) - 1);
				for (i = 0; i < n; i++)
					send_item(1'b0, 8'($urandom));
			end
		end
	endtask

	initial begin : main
		int p;
		int i;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		item_ch.valid   = 1'b0;
		item_ch.cmd     = 1'b0;
		item_ch.rx_byte = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: byte extremes, zero-length frame with ticks inside,
		// checksum error that also has a foreign class and id
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_frame(ubxfr_pkg::RST_EXPECT_CLASS, ubxfr_pkg::RST_EXPECT_ID, 16'd0, 0, 100);
		send_frame(8'hFF, 8'h00, 16'd0, 1, 0);
		send_item(1'b1, 8'h00);
		send_item(1'b1, 8'hFF);
		// zero timeout: every hunting tick times out; unused index is ignored
		stop_sending();
		wait_drained();
		write_reg(ubxfr_pkg::CFG_TIMEOUT_TICKS, 16'd0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		send_item(1'b1, 8'h00);
		send_item(1'b1, 8'h00);

		// random phases over several register settings
		for (p = 0; p < 6; p++) begin
			case (p)
				0: idle_and_config(16'd1, 16'($urandom_range(255)),
					16'($urandom_range(255)));
				1: idle_and_config(16'd3, 16'h0000, 16'h00FF);
				2: idle_and_config(16'd0, 16'h00FF, 16'h0000);
				3: idle_and_config(16'd20, 16'($urandom), 16'($urandom));
				4: idle_and_config(16'($urandom_range(2, 12)), 16'h0001, 16'h0002);
				default: idle_and_config(16'd300, 16'($urandom_range(255)), 16'h0002);
			endcase
			if (p == 0) begin
				// long result stall while timeouts keep coming
				hold_request = 120;
				for (i = 0; i < 20; i++)
					send_item(1'b1, 8'($urandom));
			end
			if (p == 2) begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end
			random_traffic(PHASE_ITEMS);
			send_idle = 1'b1;
			recv_idle = 1'b1;
		end

		// largest timeout, class masked from wide data, index past one byte
		idle_and_config(16'hFFFF, 16'h5AFF, 16'h0000);
		send_frame(8'hFF, 8'h00, 16'd300, 0, 5);
		for (i = 0; i < 40; i++)
			send_item(1'b1, 8'($urandom), 1'b0);

		stop_sending();
		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
src/ubxfr_pkg.sv
src/ubxfr_if.sv
src/ubxfr_cfg_regs.sv
src/ubxfr_in_reg.sv
src/ubxfr_parser.sv
src/ubxfr_out_reg.sv
src/ubx_frame_receiver_position.sv
src/ubxfr_checker.sv
verif/testbench.sv
